// ===== rtl/abet_pkg.sv =====
// Shared types, register map and reset constants for the baseline event trigger.
package abet_pkg;

  localparam int unsigned CFG_W      = 16;  // widest configuration register
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned PCT_W      = 7;   // percent registers
  localparam int unsigned COUNT_W    = 32;  // saturating blocked count
  localparam int unsigned PCT_SCALE  = 100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALPHA   = 3'd0,
    CFG_BETA    = 3'd1,
    CFG_SMOOTH  = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_PERIOD  = 3'd4
  } cfg_addr_e;

  localparam logic [PCT_W-1:0] ALPHA_RST   = 7'd70;
  localparam logic [PCT_W-1:0] BETA_RST    = 7'd40;
  localparam logic [CFG_W-1:0] SMOOTH_RST  = 16'd3600;
  localparam logic [CFG_W-1:0] RELEASE_RST = 16'd40;
  localparam logic [CFG_W-1:0] PERIOD_RST  = 16'd2400;

  typedef struct packed {
    logic fire;
    logic blocked;
  } blk_status_t;

endpackage

// ===== rtl/abet_mul.sv =====
// Shared registered multiplier: small operand times the baseline.
module abet_mul #(
  parameter int unsigned B_W = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [abet_pkg::CFG_W-1:0]       a_i,
  input  logic [B_W-1:0]                   b_i,
  output logic [B_W+abet_pkg::CFG_W-1:0]   p_o
);

  localparam int unsigned P_W = B_W + abet_pkg::CFG_W;

  logic [P_W-1:0] p_q;
  logic [P_W-1:0] p_d;

  assign p_d = P_W'(a_i) * P_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/abet_div.sv =====
// Restoring divider, one quotient bit per cycle; dividend high part must be below the divisor.
module abet_div #(
  parameter int unsigned QUOT_W = 26
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [QUOT_W+abet_pkg::CFG_W-1:0]      dividend_i,
  input  logic [abet_pkg::CFG_W-1:0]             divisor_i,
  output logic                                   busy_o,
  output logic [QUOT_W-1:0]                      quot_o
);

  localparam int unsigned DW    = abet_pkg::CFG_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [DW-1:0]     rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [DW-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;

  assign trial = {rem_q, quo_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      // high part starts as the partial remainder
      rem_d = dividend_i[QUOT_W+DW-1:QUOT_W];
      quo_d = dividend_i[QUOT_W-1:0];
      dvs_d = divisor_i;
      cnt_d = CNT_W'(QUOT_W);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[QUOT_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
      dvs_q <= '0;
      cnt_q <= '0;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

// ===== rtl/abet_blocker.sv =====
// Blocked/clear state machine with saturating block count and periodic retrigger.
module abet_blocker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          event_i,
  input  logic [abet_pkg::CFG_W-1:0]    release_ticks_i,
  input  logic [abet_pkg::CFG_W-1:0]    period_ticks_i,
  output abet_pkg::blk_status_t         status_o
);

  localparam int unsigned CW = abet_pkg::CFG_W;
  localparam int unsigned BW = abet_pkg::COUNT_W;

  logic          blocked_q, blocked_d;
  logic [BW-1:0] bcount_q, bcount_d;
  logic [CW-1:0] pcount_q, pcount_d;
  logic [CW:0]   pcount_inc;
  logic [CW-1:0] period;
  logic          fire;

  // zero period acts as one
  assign period     = (period_ticks_i == '0) ? CW'(1) : period_ticks_i;
  assign pcount_inc = {1'b0, pcount_q} + 1'b1;

  always_comb begin
    blocked_d = blocked_q;
    bcount_d  = bcount_q;
    pcount_d  = pcount_q;
    fire      = 1'b0;
    if (event_i) begin
      if (!blocked_q) begin
        blocked_d = 1'b1;
        bcount_d  = '0;
        pcount_d  = '0;
        fire      = 1'b1;
      end else begin
        if (bcount_q != '1) begin
          bcount_d = bcount_q + 1'b1;
        end
        if (pcount_inc >= {1'b0, period}) begin
          pcount_d = '0;
          fire     = 1'b1;
        end else begin
          pcount_d = pcount_inc[CW-1:0];
        end
      end
    end else if (blocked_q) begin
      blocked_d = 1'b0;
      fire      = (bcount_q >= BW'(release_ticks_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
      bcount_q  <= '0;
      pcount_q  <= '0;
    end else if (step_i) begin
      blocked_q <= blocked_d;
      bcount_q  <= bcount_d;
      pcount_q  <= pcount_d;
    end
  end

  assign status_o.fire    = fire;
  assign status_o.blocked = blocked_d;

endmodule

// ===== rtl/adaptive_baseline_event_trigger.sv =====
// Top level: sequencer around a shared multiplier and divider, config registers, result register.
//
// Input channel: in_valid_i / in_stall_o carry one sensor sample per request in sample_level_i.
// Output channel: out_valid_o / out_stall_i carry one result per sample: trigger_fire_o,
//   attention_on_o, event_seen_o and the integer part of the baseline in baseline_whole_o.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i (0 alpha, 1 beta,
//   2 smoothing interval, 3 release retrigger ticks, 4 periodic trigger ticks); write only
//   while no sample is in flight.
// One sample is worked at a time; in_stall_o is high from acceptance until the result is
//   loaded into the output register. The first sample after reset loads the baseline and
//   goes straight to S_STEP. Other samples run through one shared multiplier: S_ALPHA,
//   S_CMP_A and S_CMP_B when the baseline is kept, and S_ALPHA, S_CMP_A, S_DIV_LD and S_DIV
//   when the baseline is updated, where the restoring divider yields one bit per cycle.
// A new sample is taken while a result still waits in the output register; the finished
//   next result holds in the sequencer until the output register frees up.
// Reset clears the sequencer, the blocked state and counters, marks the next sample as the
//   baseline load, and returns all registers to their defaults.
module adaptive_baseline_event_trigger #(
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            sample_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              trigger_fire_o,
  output logic                              attention_on_o,
  output logic                              event_seen_o,
  output logic [SAMPLE_BITS-1:0]            baseline_whole_o,
  input  logic                              cfg_we_i,
  input  logic [abet_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [abet_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned CW   = abet_pkg::CFG_W;
  localparam int unsigned PW_  = abet_pkg::PCT_W;
  localparam int unsigned BW   = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned PRW  = BW + CW;
  localparam int unsigned LX_W = SAMPLE_BITS + PW_;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALPHA,
    S_CMP_A,
    S_CMP_B,
    S_DIV_LD,
    S_DIV,
    S_STEP
  } state_e;

  // configuration registers
  logic [PW_-1:0] alpha_q, beta_q;
  logic [CW-1:0]  smooth_q, release_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= abet_pkg::ALPHA_RST;
      beta_q    <= abet_pkg::BETA_RST;
      smooth_q  <= abet_pkg::SMOOTH_RST;
      release_q <= abet_pkg::RELEASE_RST;
      period_q  <= abet_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        abet_pkg::CFG_ALPHA:   alpha_q   <= cfg_wdata_i[PW_-1:0];
        abet_pkg::CFG_BETA:    beta_q    <= cfg_wdata_i[PW_-1:0];
        abet_pkg::CFG_SMOOTH:  smooth_q  <= cfg_wdata_i;
        abet_pkg::CFG_RELEASE: release_q <= cfg_wdata_i;
        abet_pkg::CFG_PERIOD:  period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e          state_q, state_d;
  logic [SAMPLE_BITS-1:0] level_q, level_d;
  logic [BW-1:0]   base_q, base_d;
  logic            first_q, first_d;
  logic            event_q, event_d;
  logic            upd_q, upd_d;
  logic            ovalid_q, ovalid_d;
  logic            fire_q, fire_d;
  logic            attn_q, attn_d;
  logic            oevent_q, oevent_d;
  logic [SAMPLE_BITS-1:0] owhole_q, owhole_d;

  logic [BW-1:0]   scaled;
  logic [LX_W-1:0] level_x100;
  logic [PRW-1:0]  scaled100;
  logic [CW-1:0]   smooth_n, smooth_nm1;
  logic [CW-1:0]   mul_a;
  logic            mul_en;
  logic [PRW-1:0]  prod;
  logic            div_start, div_busy;
  logic [BW-1:0]   quot;
  logic            above_alpha;
  logic            blk_step;
  logic            out_free;
  abet_pkg::blk_status_t blk_status;

  assign scaled     = {level_q, {FRACTION_BITS{1'b0}}};
  assign level_x100 = LX_W'(level_q) * LX_W'(abet_pkg::PCT_SCALE);
  assign scaled100  = PRW'({level_x100, {FRACTION_BITS{1'b0}}});
  assign smooth_n   = (smooth_q == '0) ? CW'(1) : smooth_q;
  assign smooth_nm1 = smooth_n - 1'b1;
  assign above_alpha = (scaled100 > prod);
  assign out_free   = !ovalid_q || !out_stall_i;

  // shared multiplier operand: alpha first, then beta or n-1 by the alpha outcome
  always_comb begin
    mul_en = 1'b0;
    mul_a  = CW'(alpha_q);
    case (state_q)
      S_ALPHA: begin
        mul_en = 1'b1;
        mul_a  = CW'(alpha_q);
      end
      S_CMP_A: begin
        mul_en = 1'b1;
        mul_a  = above_alpha ? smooth_nm1 : CW'(beta_q);
      end
      default: ;
    endcase
  end

  abet_mul #(
    .B_W (BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (base_q),
    .p_o    (prod)
  );

  assign div_start = (state_q == S_DIV_LD);

  abet_div #(
    .QUOT_W (BW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod + PRW'(scaled)),
    .divisor_i  (smooth_n),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign blk_step = (state_q == S_STEP) && out_free;

  abet_blocker u_blocker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (blk_step),
    .event_i         (event_q),
    .release_ticks_i (release_q),
    .period_ticks_i  (period_q),
    .status_o        (blk_status)
  );

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    base_d   = base_q;
    first_d  = first_q;
    event_d  = event_q;
    upd_d    = upd_q;
    ovalid_d = ovalid_q;
    fire_d   = fire_q;
    attn_d   = attn_q;
    oevent_d = oevent_q;
    owhole_d = owhole_q;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          level_d = sample_level_i;
          event_d = 1'b0;
          upd_d   = 1'b0;
          state_d = first_q ? S_STEP : S_ALPHA;
          if (first_q) begin
            first_d = 1'b0;
            base_d  = {sample_level_i, {FRACTION_BITS{1'b0}}};
          end
        end
      end
      S_ALPHA: state_d = S_CMP_A;
      S_CMP_A: begin
        upd_d   = above_alpha;
        state_d = above_alpha ? S_DIV_LD : S_CMP_B;
      end
      S_CMP_B: begin
        event_d = (scaled100 < prod);
        state_d = S_STEP;
      end
      S_DIV_LD: state_d = S_DIV;
      S_DIV: begin
        if (!div_busy) begin
          base_d  = quot;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ovalid_d = 1'b1;
          fire_d   = blk_status.fire;
          attn_d   = blk_status.blocked;
          oevent_d = event_q;
          owhole_d = base_q[BW-1:FRACTION_BITS];
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      level_q  <= '0;
      base_q   <= '0;
      first_q  <= 1'b1;
      event_q  <= 1'b0;
      upd_q    <= 1'b0;
      ovalid_q <= 1'b0;
      fire_q   <= 1'b0;
      attn_q   <= 1'b0;
      oevent_q <= 1'b0;
      owhole_q <= '0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      base_q   <= base_d;
      first_q  <= first_d;
      event_q  <= event_d;
      upd_q    <= upd_d;
      ovalid_q <= ovalid_d;
      fire_q   <= fire_d;
      attn_q   <= attn_d;
      oevent_q <= oevent_d;
      owhole_q <= owhole_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = ovalid_q;
  assign trigger_fire_o   = fire_q;
  assign attention_on_o   = attn_q;
  assign event_seen_o     = oevent_q;
  assign baseline_whole_o = owhole_q;

  // an event always leaves the block in the blocked state
  a_event_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_seen_o) |-> attention_on_o)
    else $error("event result without attention");

  // a non-event always clears the blocked state
  a_clear_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !event_seen_o) |-> !attention_on_o)
    else $error("non-event result left attention on");

  // an updating sample is never an event
  a_update_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && upd_q) |-> !event_q)
    else $error("baseline update flagged as event");

  // a sample request is worked before the next one is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while working");

endmodule
